// ===== rtl/mqtt_fixed_header_parser_macros.svh =====
// assertion macros for the mqtt fixed header parser
// used by the modules that carry concurrent checks; no other dependencies
`ifndef MQTT_FIXED_HEADER_PARSER_MACROS_SVH
`define MQTT_FIXED_HEADER_PARSER_MACROS_SVH

// same-cycle implication, held off during reset
`define MFHP_ASSERT_IMPL(label, clock, reset, ante, cons) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
    else $error("mfhp assertion failed");

// next-cycle implication, held off during reset
`define MFHP_ASSERT_NEXT(label, clock, reset, ante, cons) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
    else $error("mfhp assertion failed");

`endif

// ===== rtl/mfhp_pkg.sv =====
// shared types and constants for the mqtt fixed header parser
// no dependencies; imported by every module of the block
package mfhp_pkg;

  localparam int ByteW   = 8;
  localparam int AfterW  = 32;
  localparam int NibbleW = 4;
  localparam int LenW    = 28;
  localparam int GroupW  = 7;
  localparam int PosW    = 3;

  localparam logic [PosW-1:0] FirstPos   = 3'd0;
  localparam logic [PosW-1:0] LastLenPos = 3'd4;

  // packet types that carry flag bits
  localparam logic [NibbleW-1:0] TypePublish = 4'd3;
  localparam logic [NibbleW-1:0] TypePubrel  = 4'd6;
  localparam logic [NibbleW-1:0] TypeSub     = 4'd8;
  localparam logic [NibbleW-1:0] TypeUnsub   = 4'd10;

  typedef enum logic [2:0] {
    StOk       = 3'd0,
    StShort    = 3'd1,
    StMalformed = 3'd2,
    StTooLong  = 3'd3,
    StBadFlags = 3'd4
  } status_t;

  typedef struct packed {
    logic [ByteW-1:0]  data_byte;
    logic [AfterW-1:0] bytes_after;
  } in_word_t;

  typedef struct packed {
    logic [NibbleW-1:0] msg_type;
    logic [NibbleW-1:0] type_flags;
    logic [LenW-1:0]    rest_length;
    status_t            status;
  } result_t;

endpackage

// ===== rtl/mfhp_in_reg.sv =====
// input register stage of the mqtt fixed header parser
// depends on mfhp_pkg
module mfhp_in_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  mfhp_pkg::in_word_t in_word,
  input  logic              take,
  output logic              q_valid,
  output mfhp_pkg::in_word_t q_word
);
  import mfhp_pkg::*;

  // held word must wait while the decode stage cannot finish it
  assign in_stall = q_valid && !take;

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (!in_stall) begin
      q_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      q_word <= in_word;
    end
  end

endmodule

// ===== rtl/mfhp_decode.sv =====
// header state and per-byte decode of the mqtt fixed header parser
// depends on mfhp_pkg and the assertion macro header
`include "mqtt_fixed_header_parser_macros.svh"

module mfhp_decode (
  input  logic               clk,
  input  logic               rst,
  input  mfhp_pkg::in_word_t word,
  input  logic               fire,
  output logic               emit,
  output mfhp_pkg::result_t  result
);
  import mfhp_pkg::*;

  logic [PosW-1:0]    byte_position, byte_position_next;
  logic [NibbleW-1:0] held_type, held_type_next;
  logic [NibbleW-1:0] held_flags, held_flags_next;
  logic [LenW-1:0]    length_accumulator, length_accumulator_next;

  logic [GroupW-1:0]  group;
  logic               cont;
  logic               first;
  logic               buf_end;
  logic [LenW-1:0]    placed;
  logic               flags_ok;
  status_t            status_sel;

  assign group   = word.data_byte[GroupW-1:0];
  assign cont    = word.data_byte[ByteW-1];
  assign buf_end = (word.bytes_after == '0);
  assign first   = (byte_position == FirstPos) || (byte_position > LastLenPos);

  // place the seven-bit group, low group first
  always_comb begin
    case (byte_position)
      3'd1:    placed = {21'd0, group};
      3'd2:    placed = {14'd0, group, 7'd0};
      3'd3:    placed = {7'd0, group, 14'd0};
      3'd4:    placed = {group, 21'd0};
      default: placed = '0;
    endcase
  end

  assign flags_ok = (held_flags == '0) || (held_type == TypePublish) ||
                    (held_type == TypePubrel) || (held_type == TypeSub) ||
                    (held_type == TypeUnsub);

  always_comb begin
    byte_position_next      = byte_position;
    held_type_next          = held_type;
    held_flags_next         = held_flags;
    length_accumulator_next = length_accumulator;
    emit                    = 1'b0;
    status_sel              = StOk;
    if (first) begin
      held_type_next          = word.data_byte[ByteW-1:NibbleW];
      held_flags_next         = word.data_byte[NibbleW-1:0];
      length_accumulator_next = '0;
      if (buf_end) begin
        emit                = 1'b1;
        status_sel          = StShort;
        byte_position_next  = FirstPos;
      end else begin
        byte_position_next  = 3'd1;
      end
    end else begin
      length_accumulator_next = length_accumulator | placed;
      if (!cont) begin
        emit               = 1'b1;
        byte_position_next = FirstPos;
        if (word.bytes_after < {4'd0, length_accumulator_next}) begin
          status_sel = StTooLong;
        end else if (!flags_ok) begin
          status_sel = StBadFlags;
        end else begin
          status_sel = StOk;
        end
      end else if (byte_position == LastLenPos) begin
        emit               = 1'b1;
        status_sel         = StMalformed;
        byte_position_next = FirstPos;
      end else if (buf_end) begin
        emit               = 1'b1;
        status_sel         = StShort;
        byte_position_next = FirstPos;
      end else begin
        byte_position_next = byte_position + 3'd1;
      end
    end
  end

  always_comb begin
    result.msg_type    = held_type_next;
    result.type_flags  = held_flags_next;
    result.rest_length = length_accumulator_next;
    result.status      = status_sel;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position      <= FirstPos;
      held_type          <= '0;
      held_flags         <= '0;
      length_accumulator <= '0;
    end else if (fire) begin
      byte_position      <= byte_position_next;
      held_type          <= held_type_next;
      held_flags         <= held_flags_next;
      length_accumulator <= length_accumulator_next;
    end
  end

  `MFHP_ASSERT_IMPL(a_pos_range, clk, rst, 1'b1, byte_position <= LastLenPos)
  `MFHP_ASSERT_NEXT(a_emit_restarts, clk, rst, fire && emit, byte_position == FirstPos)
  `MFHP_ASSERT_IMPL(a_malformed_last, clk, rst, emit && (status_sel == StMalformed),
                    byte_position == LastLenPos)
  `MFHP_ASSERT_NEXT(a_first_clears_len, clk, rst, fire && first,
                    length_accumulator == '0)

endmodule

// ===== rtl/mfhp_out_reg.sv =====
// result register of the mqtt fixed header parser
// depends on mfhp_pkg
module mfhp_out_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  mfhp_pkg::result_t d,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              free,
  output mfhp_pkg::result_t q
);
  import mfhp_pkg::*;

  // a new word may enter when the register is empty or being drained
  assign free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      q <= d;
    end
  end

endmodule

// ===== rtl/mqtt_fixed_header_parser.sv =====
// top level of the mqtt fixed header parser
// depends on mfhp_pkg, mfhp_in_reg, mfhp_decode, mfhp_out_reg and the macro header
//
// channel | handshake            | word
// in      | in_valid, in_stall   | data_byte, bytes_after
// out     | out_valid, out_stall | msg_type, type_flags, rest_length, status
//
// one byte accepted per cycle while in_stall is low; the byte that ends a header passes
// the input register and decode step; its result then waits in the result register
// the rate is set by the single decode step between input and result registers
// reset returns to the first byte of a header and empties both registers
// a stalled result holds; bytes that end no header still pass while it waits
`include "mqtt_fixed_header_parser_macros.svh"

module mqtt_fixed_header_parser (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic [31:0] bytes_after,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  msg_type,
  output logic [3:0]  type_flags,
  output logic [27:0] rest_length,
  output logic [2:0]  status
);
  import mfhp_pkg::*;

  in_word_t in_word, q_word;
  result_t  dec_result, out_result;
  logic     q_valid, emit, free, take, load;

  assign in_word.data_byte   = data_byte;
  assign in_word.bytes_after = bytes_after;

  // a held byte finishes when it makes no result or the result slot is free
  assign take = q_valid && (!emit || free);
  assign load = take && emit;

  mfhp_in_reg u_in (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_word  (in_word),
    .take     (take),
    .q_valid  (q_valid),
    .q_word   (q_word)
  );

  mfhp_decode u_dec (
    .clk    (clk),
    .rst    (rst),
    .word   (q_word),
    .fire   (take),
    .emit   (emit),
    .result (dec_result)
  );

  mfhp_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (load),
    .d         (dec_result),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .free      (free),
    .q         (out_result)
  );

  assign msg_type    = out_result.msg_type;
  assign type_flags  = out_result.type_flags;
  assign rest_length = out_result.rest_length;
  assign status      = out_result.status;

  `MFHP_ASSERT_IMPL(a_load_has_room, clk, rst, load, !out_valid || !out_stall)
  `MFHP_ASSERT_NEXT(a_load_shows, clk, rst, load, out_valid)
  `MFHP_ASSERT_IMPL(a_take_needs_word, clk, rst, take, q_valid)

endmodule

// ===== dv/tb.sv =====
// testbench for mqtt_fixed_header_parser: drives header bytes, predicts each
// header result and checks it in order; depends on mfhp_pkg and the rtl top
module tb;
  import mfhp_pkg::*;

  // predicts header results byte by byte and holds them until they come out
  class header_scoreboard;
    logic [PosW-1:0]    hdr_pos;
    logic [NibbleW-1:0] hdr_type;
    logic [NibbleW-1:0] hdr_flags;
    logic [LenW-1:0]    len_acc;
    result_t            pending_headers[$];
    int                 bytes_in;
    int                 errors;
    int                 status_seen[5];

    function new();
      hdr_pos   = FirstPos;
      hdr_type  = '0;
      hdr_flags = '0;
      len_acc   = '0;
      bytes_in  = 0;
      errors    = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
    endfunction

    function void finish_header(status_t st);
      result_t r;
      r.msg_type    = hdr_type;
      r.type_flags  = hdr_flags;
      r.rest_length = len_acc;
      r.status      = st;
      pending_headers.push_back(r);
      hdr_pos = FirstPos;
    endfunction

    function void decode_byte(logic [ByteW-1:0] b, logic [AfterW-1:0] after);
      logic flags_ok;
      bytes_in++;
      if (hdr_pos == FirstPos || hdr_pos > LastLenPos) begin
        hdr_type  = b[7:4];
        hdr_flags = b[3:0];
        len_acc   = '0;
        if (after == 0) finish_header(StShort);
        else hdr_pos = 3'd1;
        return;
      end
      len_acc = len_acc | (LenW'(b[GroupW-1:0]) << (GroupW * (hdr_pos - 1)));
      flags_ok = (hdr_type == TypePublish) || (hdr_type == TypePubrel) ||
                 (hdr_type == TypeSub) || (hdr_type == TypeUnsub);
      if (!b[7]) begin
        // length complete: buffer size check wins over the flag check
        if (after < {4'd0, len_acc}) finish_header(StTooLong);
        else if (hdr_flags != 0 && !flags_ok) finish_header(StBadFlags);
        else finish_header(StOk);
      end else if (hdr_pos == LastLenPos) begin
        finish_header(StMalformed);
      end else if (after == 0) begin
        finish_header(StShort);
      end else begin
        hdr_pos = hdr_pos + 3'd1;
      end
    endfunction

    function void check_result(logic [NibbleW-1:0] got_type, logic [NibbleW-1:0] got_flags,
                               logic [LenW-1:0] got_len, logic [2:0] got_status);
      result_t exp;
      if (pending_headers.size() == 0) begin
        $display("%0t: unexpected result type %0d flags %0d length %0d status %0d",
                 $time, got_type, got_flags, got_len, got_status);
        errors++;
        return;
      end
      exp = pending_headers.pop_front();
      if (got_status <= 3'd4) status_seen[got_status]++;
      if (got_type !== exp.msg_type) begin
        $display("%0t: msg_type expected %0d got %0d", $time, exp.msg_type, got_type);
        errors++;
      end
      if (got_flags !== exp.type_flags) begin
        $display("%0t: type_flags expected %0d got %0d", $time, exp.type_flags, got_flags);
        errors++;
      end
      if (got_len !== exp.rest_length) begin
        $display("%0t: rest_length expected %0d got %0d",
                 $time, exp.rest_length, got_len);
        errors++;
      end
      if (got_status !== exp.status) begin
        $display("%0t: status expected %0d got %0d", $time, exp.status, got_status);
        errors++;
      end
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [ByteW-1:0]   data_byte = '0;
  logic [AfterW-1:0]  bytes_after = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [NibbleW-1:0] msg_type;
  logic [NibbleW-1:0] type_flags;
  logic [LenW-1:0]    rest_length;
  logic [2:0]         status;

  header_scoreboard hdr_sb = new();
  bit quiet = 1'b0;
  bit hold_req = 1'b0;

  mqtt_fixed_header_parser i_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .data_byte   (data_byte),
    .bytes_after (bytes_after),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .msg_type    (msg_type),
    .type_flags  (type_flags),
    .rest_length (rest_length),
    .status      (status)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #5000000;
    $display("CHECK FAILED");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      hdr_sb.check_result(msg_type, type_flags, rest_length, status);
  end

  // result side: random stalls, plus a long hold-off on request
  initial begin
    int stall_left;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        stall_left = 400;
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else if (quiet || $urandom_range(0, 99) < 70) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= 1'b1;
        stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 2);
      end
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  task automatic send_byte(input logic [ByteW-1:0] b, input logic [AfterW-1:0] after);
    int gap;
    gap = quiet ? 0 : pick_gap();
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid    <= 1'b1;
    data_byte   <= b;
    bytes_after <= after;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    hdr_sb.decode_byte(b, after);
  endtask

  task automatic wait_results_drained();
    while (hdr_sb.pending_headers.size() != 0) @(posedge clk);
  endtask

  // one header with random content; mostly well formed, some broken, some noise
  task automatic send_header();
    logic [NibbleW-1:0] ptype, pflags;
    logic [GroupW-1:0]  grp[4];
    logic [ByteW-1:0]   lb[4];
    logic [LenW-1:0]    len;
    logic [AfterW-1:0]  payload;
    int n, kind, cut, r;
    ptype  = $urandom_range(0, 15);
    pflags = ($urandom_range(0, 99) < 50) ? 4'd0 : 4'($urandom_range(0, 15));
    r = $urandom_range(0, 99);
    n = (r < 45) ? 1 : (r < 70) ? 2 : (r < 88) ? 3 : 4;
    kind = $urandom_range(0, 99);
    if (kind >= 90) begin
      send_byte(ByteW'($urandom_range(0, 255)), $urandom);
      return;
    end
    if (kind >= 82) n = 4;
    len = '0;
    for (int i = 0; i < 4; i++) begin
      r = $urandom_range(0, 9);
      grp[i] = (r == 0) ? 7'd0 : (r == 1) ? 7'd127 : 7'($urandom_range(0, 127));
      lb[i] = {(i < n - 1) || (kind >= 82), grp[i]};
      if (i < n) len = len | (LenW'(grp[i]) << (GroupW * i));
    end
    if (kind >= 70 && kind < 82) begin
      // buffer runs out before the length is complete
      cut = $urandom_range(0, n - 1);
      send_byte({ptype, pflags}, cut);
      for (int k = 1; k <= cut; k++) send_byte(lb[k-1], cut - k);
      return;
    end
    if (kind >= 82) begin
      send_byte({ptype, pflags}, 4 + $urandom_range(0, 50));
      for (int i = 0; i < 4; i++)
        send_byte(lb[i], (i == 3) ? $urandom_range(0, 3) : 3 - i + $urandom_range(0, 50));
      return;
    end
    if (kind >= 58 && len != 0) begin
      payload = $urandom_range(int'(len) - 1);
    end else begin
      payload = ($urandom_range(0, 3) == 0) ? $urandom : {4'd0, len} + $urandom_range(0, 30);
      if (payload < {4'd0, len}) payload = {4'd0, len};
    end
    send_byte({ptype, pflags}, payload + n);
    for (int i = 0; i < n; i++) send_byte(lb[i], payload + (n - 1 - i));
  endtask

  initial begin
    int start_bytes;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    quiet = 1'b1;
    // buffer ends after the first byte
    send_byte(8'h3F, 32'd0);
    // buffer ends inside the length
    send_byte(8'h30, 32'd5);
    send_byte(8'h85, 32'd0);
    // fourth length byte still continues
    send_byte(8'h82, 32'd10);
    send_byte(8'hFF, 32'd9);
    send_byte(8'hFF, 32'd8);
    send_byte(8'hFF, 32'd7);
    send_byte(8'h80, 32'd6);
    // largest length, reserved type 15, full buffer count
    send_byte(8'hF0, 32'hFFFF_FFFF);
    send_byte(8'hFF, 32'hFFFF_FFFF);
    send_byte(8'hFF, 32'hFFFF_FFFF);
    send_byte(8'hFF, 32'hFFFF_FFFF);
    send_byte(8'h7F, 32'hFFFF_FFFF);
    // length exceeds buffer
    send_byte(8'h62, 32'd3);
    send_byte(8'h05, 32'd4);
    // reserved type 0 with flags, zero length at buffer end
    send_byte(8'h01, 32'd1);
    send_byte(8'h00, 32'd0);
    // flagged types that allow flags
    send_byte(8'hA2, 32'd1);
    send_byte(8'h02, 32'd2);
    send_byte(8'h8F, 32'd1);
    send_byte(8'h7F, 32'd127);
    @(negedge clk);
    in_valid <= 1'b0;
    wait_results_drained();

    // output held off while bytes keep coming, so the input must stall
    hold_req = 1'b1;
    repeat (40) send_header();
    @(negedge clk);
    in_valid <= 1'b0;
    wait_results_drained();
    quiet = 1'b0;

    start_bytes = hdr_sb.bytes_in;
    for (int chunk = 0; hdr_sb.bytes_in - start_bytes < 650; chunk++) begin
      quiet = (chunk % 4 == 1);
      repeat (30) send_header();
      if (chunk % 3 == 2) begin
        @(negedge clk);
        in_valid <= 1'b0;
        wait_results_drained();
      end
    end
    @(negedge clk);
    in_valid <= 1'b0;
    wait_results_drained();
    repeat (10) @(posedge clk);

    $display("%0d header bytes driven; results seen: ok %0d, short %0d, malformed %0d,",
             hdr_sb.bytes_in, hdr_sb.status_seen[StOk], hdr_sb.status_seen[StShort],
             hdr_sb.status_seen[StMalformed]);
    $display("too long %0d, bad flags %0d, with random idling and a long output hold-off",
             hdr_sb.status_seen[StTooLong], hdr_sb.status_seen[StBadFlags]);
    if (hdr_sb.errors == 0 && hdr_sb.pending_headers.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/mfhp_pkg.sv
rtl/mfhp_in_reg.sv
rtl/mfhp_decode.sv
rtl/mfhp_out_reg.sv
rtl/mqtt_fixed_header_parser.sv
dv/tb.sv
